// ===== design/rarmt_pkg.sv =====
// Shared types and constants for the range-assign / range-minimum store.
// Used by the controller, the datapath and the top level.
`default_nettype none
package rarmt_pkg;
    localparam int LEAVES_DEF     = 1024;
    localparam int VALUE_BITS_DEF = 20;
    localparam int FIELD_W        = 20;
    localparam int POS_W          = 11;
    localparam logic [FIELD_W-1:0] EMPTY_RESET = 20'd1000000;

    localparam logic KIND_QUERY  = 1'b0;
    localparam logic KIND_ASSIGN = 1'b1;

    typedef struct packed {
        logic clear;
        logic load;
        logic step;
        logic reply;
        logic reply_empty;
    } rarmt_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic scan_last;
        logic range_empty;
        logic is_query;
        logic in_query;
    } rarmt_status_t;
endpackage
`default_nettype wire

// ===== design/rarmt_ctrl.sv =====
// Controller state machine: clearing pass, idle, range scan and drain.
// Depends on rarmt_pkg for command and status types.
`default_nettype none
module rarmt_ctrl
    import rarmt_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire rarmt_status_t status,
    output rarmt_cmd_t         cmd,
    output logic               busy
);
    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_DRAIN = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (status.range_empty)
                    begin
                        // empty range: queries answer at once, assigns drop
                        cmd.reply       = status.in_query;
                        cmd.reply_empty = status.in_query;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = status.is_query ? ST_DRAIN : ST_IDLE;
                end
            end
            ST_DRAIN:
            begin
                cmd.reply  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end
endmodule
`default_nettype wire

// ===== design/rarmt_dpath.sv =====
// Datapath: position store, scan counter, running minimum and result word.
// Depends on rarmt_pkg for command and status types and field widths.
`default_nettype none
module rarmt_dpath
    import rarmt_pkg::*;
#(
    parameter int LEAVES     = LEAVES_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire rarmt_cmd_t         cmd,
    output rarmt_status_t           status,
    input  wire logic               kind,
    input  wire logic [POS_W-1:0]   range_lo,
    input  wire logic [POS_W-1:0]   range_hi,
    input  wire logic [FIELD_W-1:0] value,
    input  wire logic               empty_value_we,
    input  wire logic [FIELD_W-1:0] empty_value,
    output logic                    done,
    output logic [FIELD_W-1:0]      min_value
);
    localparam int ADDR_W = (LEAVES > 1) ? $clog2(LEAVES) : 1;
    localparam int CNT_W  = $clog2(LEAVES + 1);
    localparam logic [FIELD_W-1:0] VAL_MASK = (VALUE_BITS >= FIELD_W) ?
        {FIELD_W{1'b1}} : FIELD_W'((64'd1 << VALUE_BITS) - 64'd1);

    logic [FIELD_W-1:0] mem [LEAVES];

    logic [CNT_W-1:0]   pos_reg;
    logic [CNT_W-1:0]   end_reg;
    logic               kind_reg;
    logic [FIELD_W-1:0] val_reg;
    logic [FIELD_W-1:0] acc_reg;
    logic [FIELD_W-1:0] rd_reg;
    logic               rd_vld_reg;
    logic [FIELD_W-1:0] empty_reg;
    logic               done_reg;
    logic [FIELD_W-1:0] min_value_reg;

    logic [31:0]        hi_clip;
    logic [FIELD_W-1:0] acc_next;
    logic               mem_we;
    logic [FIELD_W-1:0] mem_wd;

    assign hi_clip = (32'(range_hi) > 32'(LEAVES)) ? 32'(LEAVES) : 32'(range_hi);

    assign status.range_empty = 32'(range_lo) >= hi_clip;
    assign status.in_query    = kind == KIND_QUERY;
    assign status.is_query    = kind_reg == KIND_QUERY;
    assign status.clear_last  = pos_reg == CNT_W'(LEAVES - 1);
    assign status.scan_last   = CNT_W'(pos_reg + CNT_W'(1)) == end_reg;

    assign acc_next = (rd_vld_reg && rd_reg < acc_reg) ? rd_reg : acc_reg;

    assign mem_we = cmd.clear || (cmd.step && kind_reg == KIND_ASSIGN);
    assign mem_wd = cmd.clear ? (EMPTY_RESET & VAL_MASK) : val_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[pos_reg[ADDR_W-1:0]] <= mem_wd;
        end
        rd_reg <= mem[pos_reg[ADDR_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            rd_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
            empty_reg  <= EMPTY_RESET & VAL_MASK;
        end
        else
        begin
            if (empty_value_we)
            begin
                empty_reg <= empty_value & VAL_MASK;
            end
            if (cmd.load)
            begin
                pos_reg <= range_lo[CNT_W-1:0] & CNT_W'({POS_W{1'b1}});
            end
            else if (cmd.clear || cmd.step)
            begin
                pos_reg <= CNT_W'(pos_reg + CNT_W'(1));
            end
            rd_vld_reg <= cmd.step && kind_reg == KIND_QUERY;
            done_reg   <= cmd.reply;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            end_reg  <= hi_clip[CNT_W-1:0];
            kind_reg <= kind;
            val_reg  <= value & VAL_MASK;
            acc_reg  <= {FIELD_W{1'b1}};
        end
        else
        begin
            acc_reg <= acc_next;
        end
        if (cmd.reply)
        begin
            min_value_reg <= cmd.reply_empty ? empty_reg : acc_next;
        end
    end

    assign done      = done_reg;
    assign min_value = min_value_reg;
endmodule
`default_nettype wire

// ===== design/range_assign_range_min_tree.sv =====
// Range assign / range minimum store. An item covers positions lo up to but not
// including hi (hi clipped to LEAVES), one position per cycle through the single
// port of the position store, and a query then passes the drain state before its
// result strobe; an empty range does not raise busy, and an empty query strobes its result next.
// After reset a clearing pass over every position keeps busy high.
// The result strobe lasts one cycle; the receiver cannot stall.
`default_nettype none
module range_assign_range_min_tree
    import rarmt_pkg::*;
#(
    parameter int LEAVES     = LEAVES_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               kind,
    input  wire logic [POS_W-1:0]   range_lo,
    input  wire logic [POS_W-1:0]   range_hi,
    input  wire logic [FIELD_W-1:0] value,
    input  wire logic               empty_value_we,
    input  wire logic [FIELD_W-1:0] empty_value,
    output logic                    done,
    output logic [FIELD_W-1:0]      min_value
);
    rarmt_cmd_t    cmd;
    rarmt_status_t status;

    rarmt_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    rarmt_dpath #(
        .LEAVES     (LEAVES),
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .kind           (kind),
        .range_lo       (range_lo),
        .range_hi       (range_hi),
        .value          (value),
        .empty_value_we (empty_value_we),
        .empty_value    (empty_value),
        .done           (done),
        .min_value      (min_value)
    );

`ifndef SYNTHESIS
    a_assign_no_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == KIND_ASSIGN) |=> !done)
        else $error("assign produced a result word");

    a_empty_query_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == KIND_QUERY && status.range_empty) |=> done)
        else $error("empty query gave no result word");

    a_reply_single: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.reply && cmd.step) |-> 1'b0)
        else $error("reply issued during scan");
`endif
endmodule
`default_nettype wire
